### sv/firdbt_pkg.sv
package firdbt_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned FRAC_W   = 15;

  localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
  localparam logic [OP_W-1:0] OP_TAP_WR = 2'd1;
  localparam logic [OP_W-1:0] OP_SWAP   = 2'd2;

  // shared controls fanned out to every cell
  typedef struct packed {
    logic                shift;
    logic                bank_sel;
    logic [SAMPLE_W-1:0] wr_value;
  } cell_ctl_t;

endpackage

### sv/fir_filter_double_buffered_taps.sv
// Direct-form FIR filter built as a row of TAPS cells. Each cell holds one history
// sample and its tap in two banks (active and shadow); a swap request flips the
// bank select, a tap-write request loads the shadow bank, both with no result. A
// filter request shifts the sample into the row, then a partial sum walks the row
// one cell per clock, each cell adding its tap times its sample. The sum is
// rounded to Q1.15 and saturated into the output register. A filter request's
// result passes the start register, the TAPS-cell walk and the output register,
// and the next request is taken only once the result has reached the output
// register. All history and coefficients reset to zero. Tap writes to an index of
// TAPS or more are dropped.
module fir_filter_double_buffered_taps #(
  parameter int unsigned TAPS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // sample[15:0], tap_index[20:16], tap_value[36:21], zero
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // filtered[15:0]
  output logic        m_axis_tuser   // saturated
);

  localparam int unsigned ACC_W = firdbt_pkg::PROD_W + 1 + $clog2(TAPS);
  localparam int unsigned RND_W = ACC_W + 1;
  localparam int unsigned Q_W   = RND_W - firdbt_pkg::FRAC_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state_d, state_q;
  logic       bank_sel_d, bank_sel_q;
  logic       start_q;
  logic       accept, acc_filter, acc_wr, acc_swap;
  logic       last_valid, out_free, load_en;

  logic [firdbt_pkg::OP_W-1:0]              operation;
  logic signed [firdbt_pkg::SAMPLE_W-1:0]   sample;
  logic [firdbt_pkg::IDX_W-1:0]             tap_index;
  logic signed [firdbt_pkg::SAMPLE_W-1:0]   tap_value;

  firdbt_pkg::cell_ctl_t ctl;

  logic signed [firdbt_pkg::SAMPLE_W-1:0] x_out [TAPS];
  logic signed [ACC_W-1:0]                psum_out [TAPS];
  logic [TAPS-1:0]                        valid_out;
  logic [TAPS-1:0]                        wr_en;

  logic signed [RND_W-1:0] rnd;
  logic signed [Q_W-1:0]   q;
  logic                    sat;
  logic [15:0]             filtered;

  logic [15:0] out_data_q;
  logic        out_sat_q;
  logic        out_valid_q;

  assign operation = s_axis_tuser;
  assign sample    = s_axis_tdata[15:0];
  assign tap_index = s_axis_tdata[20:16];
  assign tap_value = s_axis_tdata[36:21];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign acc_filter    = accept && (operation == firdbt_pkg::OP_FILTER);
  assign acc_wr        = accept && (operation == firdbt_pkg::OP_TAP_WR);
  assign acc_swap      = accept && (operation == firdbt_pkg::OP_SWAP);

  assign ctl.shift    = acc_filter;
  assign ctl.bank_sel = bank_sel_q;
  assign ctl.wr_value = tap_value;

  assign bank_sel_d = acc_swap ? !bank_sel_q : bank_sel_q;

  genvar k;
  generate
    for (k = 0; k < TAPS; k++) begin : g_cell
      if (k < (1 << firdbt_pkg::IDX_W)) begin : g_wr
        assign wr_en[k] = acc_wr && (tap_index == firdbt_pkg::IDX_W'(k));
      end else begin : g_nowr
        assign wr_en[k] = 1'b0;
      end

      if (k == 0) begin : g_head
        firdbt_cell #(.ACC_W(ACC_W)) u_cell (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .ctl_i   (ctl),
          .wr_en_i (wr_en[k]),
          .x_i     (sample),
          .x_o     (x_out[k]),
          .valid_i (start_q),
          .psum_i  ('0),
          .valid_o (valid_out[k]),
          .psum_o  (psum_out[k])
        );
      end else begin : g_body
        firdbt_cell #(.ACC_W(ACC_W)) u_cell (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .ctl_i   (ctl),
          .wr_en_i (wr_en[k]),
          .x_i     (x_out[k-1]),
          .x_o     (x_out[k]),
          .valid_i (valid_out[k-1]),
          .psum_i  (psum_out[k-1]),
          .valid_o (valid_out[k]),
          .psum_o  (psum_out[k])
        );
      end
    end
  endgenerate

  assign last_valid = valid_out[TAPS-1];
  assign out_free   = !out_valid_q || m_axis_tready;
  assign load_en    = ((state_q == ST_RUN && last_valid) || state_q == ST_WAIT) && out_free;

  // round half up at bit 14, then keep the integer part of the Q1.15 scale
  assign rnd = {psum_out[TAPS-1][ACC_W-1], psum_out[TAPS-1]} + RND_W'(16384);
  assign q   = rnd[RND_W-1:firdbt_pkg::FRAC_W];
  assign sat = !((&q[Q_W-1:15]) || !(|q[Q_W-1:15]));
  assign filtered = sat ? (q[Q_W-1] ? 16'h8000 : 16'h7fff) : q[15:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_filter) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_valid) begin
          state_d = out_free ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_sel_q  <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      bank_sel_q <= bank_sel_d;
      start_q    <= acc_filter;
      if (load_en) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      out_data_q <= filtered;
      out_sat_q  <= sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  // the input side is only open when no sum is walking the row
  a_idle_no_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (valid_out == '0 && !start_q))
    else $error("request taken while a sum is in flight");

  a_one_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_out) <= 1)
    else $error("more than one partial sum in the row");

  a_last_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_valid |-> (state_q == ST_RUN))
    else $error("sum finished outside of a run");

  a_start_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_filter |=> (start_q && state_q == ST_RUN))
    else $error("filter request did not start a sweep");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en |=> m_axis_tvalid)
    else $error("result loaded but not presented");

endmodule

### sv/firdbt_cell.sv
module firdbt_cell #(
  parameter int unsigned ACC_W = 38
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  firdbt_pkg::cell_ctl_t                ctl_i,
  input  logic                                 wr_en_i,
  input  logic signed [firdbt_pkg::SAMPLE_W-1:0] x_i,
  output logic signed [firdbt_pkg::SAMPLE_W-1:0] x_o,
  input  logic                                 valid_i,
  input  logic signed [ACC_W-1:0]              psum_i,
  output logic                                 valid_o,
  output logic signed [ACC_W-1:0]              psum_o
);

  logic signed [firdbt_pkg::SAMPLE_W-1:0] x_q;
  logic signed [firdbt_pkg::SAMPLE_W-1:0] bank0_q, bank1_q;
  logic signed [firdbt_pkg::SAMPLE_W-1:0] coef;
  logic signed [firdbt_pkg::PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]                psum_d, psum_q;
  logic                                   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      bank0_q <= '0;
      bank1_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl_i.shift) begin
        x_q <= x_i;
      end
      // writes always land in the bank that is not in use
      if (wr_en_i && ctl_i.bank_sel) begin
        bank0_q <= ctl_i.wr_value;
      end
      if (wr_en_i && !ctl_i.bank_sel) begin
        bank1_q <= ctl_i.wr_value;
      end
      valid_q <= valid_i;
    end
  end

  assign coef   = ctl_i.bank_sel ? bank1_q : bank0_q;
  assign prod   = coef * x_q;
  assign psum_d = psum_i + {{(ACC_W-firdbt_pkg::PROD_W){prod[firdbt_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      psum_q <= psum_d;
    end
  end

  assign x_o     = x_q;
  assign valid_o = valid_q;
  assign psum_o  = psum_q;

endmodule

### dv/tb_fir_filter_double_buffered_taps.sv
`timescale 1ns / 100ps

module tb_fir_filter_double_buffered_taps;

  localparam int TAPS = 32;
  localparam int ITEMS_PER_PHASE = 333;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [firdbt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] filtered;
    logic        saturated;
  } fir_out_t;

  typedef struct packed {
    logic [firdbt_pkg::OP_W-1:0] op;
    logic [15:0]                 sample;
    logic [4:0]                  tap_index;
    logic [15:0]                 tap_value;
    logic                        fixed_result;
    fir_out_t                    result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // sample[15:0], tap_index[20:16], tap_value[36:21], zero
  logic [1:0]  s_axis_tuser;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // filtered[15:0]
  logic        m_axis_tuser;   // saturated

  // filter state kept by the testbench
  logic signed [15:0] sample_hist [TAPS-1];
  logic signed [15:0] coef_bank [2][TAPS];
  bit                 active_bank;

  fir_out_t  pending_outputs [$];
  fir_out_t  next_output;
  stim_row_t directed_rows [DIRECTED_ROWS];
  int        fail_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_off_req;

  fir_filter_double_buffered_taps #(
    .TAPS(TAPS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // updates the filter state for one request; has_out tells if a result follows
  function automatic void fir_compute(input logic [firdbt_pkg::OP_W-1:0] op,
                                      input logic [15:0] sample,
                                      input logic [4:0] tap_index, input logic [15:0] tap_value,
                                      output bit has_out, output fir_out_t res);
    longint acc;
    longint q;
    has_out = 1'b0;
    res = '0;
    case (op)
      firdbt_pkg::OP_TAP_WR: begin
        if (int'(tap_index) < TAPS) coef_bank[!active_bank][tap_index] = tap_value;
      end
      firdbt_pkg::OP_SWAP: begin
        active_bank = !active_bank;
      end
      firdbt_pkg::OP_FILTER: begin
        acc = longint'(coef_bank[active_bank][0]) * longint'($signed(sample));
        for (int k = 1; k < TAPS; k++)
          acc += longint'(coef_bank[active_bank][k]) * longint'(sample_hist[k-1]);
        for (int k = TAPS - 2; k > 0; k--) sample_hist[k] = sample_hist[k-1];
        sample_hist[0] = sample;
        // round half up, then floor toward minus infinity
        q = (acc + 64'sd16384) >>> 15;
        res.saturated = 1'b0;
        if (q > 32767) begin
          q = 32767;
          res.saturated = 1'b1;
        end else if (q < -32768) begin
          q = -32768;
          res.saturated = 1'b1;
        end
        res.filtered = q[15:0];
        has_out = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_request(input logic [firdbt_pkg::OP_W-1:0] op,
                              input logic [15:0] sample,
                              input logic [4:0] tap_index, input logic [15:0] tap_value,
                              input logic fixed_result, input fir_out_t fixed_out);
    bit       has_out;
    fir_out_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {3'b000, tap_value, tap_index, sample};
    do @(posedge clk_i); while (!s_axis_tready);
    fir_compute(op, sample, tap_index, tap_value, has_out, res);
    if (has_out) pending_outputs.push_back(fixed_result ? fixed_out : res);
  endtask

  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    int mode;
    mode = $urandom_range(9);
    if (mode == 0) return 16'h7fff;
    if (mode == 1) return 16'h8000;
    if (mode < 6) return 16'($urandom);
    return 16'($urandom_range(8191) - 4096);
  endfunction

  function automatic logic [15:0] rand_tap();
    int mode;
    mode = $urandom_range(9);
    if (mode == 0) return 16'h7fff;
    if (mode == 1) return 16'h8000;
    if (mode < 5) return 16'($urandom);
    return 16'($urandom_range(4095) - 2048);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: filtered %0d saturated %0b", $signed(m_axis_tdata),
               m_axis_tuser);
        fail_count++;
      end else begin
        next_output = pending_outputs.pop_front();
        if (m_axis_tdata !== next_output.filtered) begin
          $error("filtered: expected %0d, got %0d", $signed(next_output.filtered),
                 $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tuser !== next_output.saturated) begin
          $error("saturated: expected %0b, got %0b", next_output.saturated, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // receiver, with an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [firdbt_pkg::OP_W-1:0] op;
    int                          pick;
    int                          issued;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    fail_count    = 0;
    hold_off_req  = 1'b0;
    active_bank   = 1'b0;
    for (int k = 0; k < TAPS - 1; k++) sample_hist[k] = '0;
    for (int k = 0; k < TAPS; k++) begin
      coef_bank[0][k] = '0;
      coef_bank[1][k] = '0;
    end

    // op, sample, tap_index, tap_value, fixed result, {filtered, saturated}
    directed_rows = '{
      '{firdbt_pkg::OP_FILTER, 16'h7fff, 5'd31, 16'hffff, 1'b1, '{16'h0000, 1'b0}},
      '{firdbt_pkg::OP_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b1, '{16'h0000, 1'b0}},
      '{OP_UNUSED,             16'h1234, 5'd31, 16'h8000, 1'b0, '0},
      '{firdbt_pkg::OP_TAP_WR, 16'hffff, 5'd0,  16'h7fff, 1'b0, '0},
      '{firdbt_pkg::OP_TAP_WR, 16'h0000, 5'd1,  16'h7fff, 1'b0, '0},
      '{firdbt_pkg::OP_TAP_WR, 16'h5555, 5'd31, 16'h8000, 1'b0, '0},
      // shadow writes must not reach the active taps
      '{firdbt_pkg::OP_FILTER, 16'h7fff, 5'd7,  16'h1234, 1'b1, '{16'h0000, 1'b0}},
      '{firdbt_pkg::OP_SWAP,   16'haaaa, 5'd31, 16'hffff, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h7fff, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h7fff, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h0000, 5'd31, 16'hffff, 1'b0, '0},
      '{firdbt_pkg::OP_TAP_WR, 16'h0000, 5'd0,  16'h8000, 1'b0, '0},
      '{firdbt_pkg::OP_TAP_WR, 16'h0000, 5'd1,  16'h8000, 1'b0, '0},
      '{firdbt_pkg::OP_SWAP,   16'h0000, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_SWAP,   16'hffff, 5'd15, 16'h7fff, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h0001, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'hffff, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_SWAP,   16'h0000, 5'd0,  16'h0000, 1'b0, '0},
      '{firdbt_pkg::OP_FILTER, 16'h0000, 5'd0,  16'h0000, 1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        foreach (directed_rows[i])
          send_request(directed_rows[i].op, directed_rows[i].sample,
                       directed_rows[i].tap_index, directed_rows[i].tap_value,
                       directed_rows[i].fixed_result, directed_rows[i].result);
      end

      // receiver stops for a while so that the block backs up onto its input
      if (phase == 2) begin
        @(posedge clk_i);
        hold_off_req = 1'b1;
      end

      issued = 0;
      while (issued < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 55) op = firdbt_pkg::OP_FILTER;
        else if (pick < 85) op = firdbt_pkg::OP_TAP_WR;
        else if (pick < 93) op = firdbt_pkg::OP_SWAP;
        else op = OP_UNUSED;
        send_request(op, rand_sample(), 5'($urandom), rand_tap(), 1'b0, '0);
        if (op != OP_UNUSED) issued++;
      end

      drain_outputs();
    end

    repeat (TAPS + 8) @(posedge clk_i);
    if (fail_count == 0 && pending_outputs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
